@@ src/bra_pkg.sv @@
// ----------------------------------------------------------------------------
// bra_pkg
// Shared constants, register map and sequencer states of the best rational
// approximation block.
// ----------------------------------------------------------------------------
`default_nettype none

package bra_pkg;

    // numerator and denominator width
    localparam int COUNT_W = 17;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int RATIO_WIDTH_DEF   = 32;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(65536);

    // configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_INDEX_W = APB_ADDR_W - 2;

    localparam logic [REG_INDEX_W-1:0] REG_LARGEST_COUNT = REG_INDEX_W'(0);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHK,
        ST_MQ,
        ST_MP,
        ST_BRK,
        ST_KDIV,
        ST_SP,
        ST_SQ,
        ST_EA,
        ST_EB,
        ST_EC,
        ST_ED,
        ST_EE,
        ST_EF,
        ST_FIN
    } bra_state_t;

endpackage

`default_nettype wire

@@ src/bra_cfg.sv @@
// ----------------------------------------------------------------------------
// bra_cfg
// Configuration register file: holds the count limit behind an APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bra_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [bra_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [bra_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready,
    output logic      [bra_pkg::COUNT_W-1:0]    limit
);
    import bra_pkg::*;

    logic [COUNT_W-1:0]     limit_reg;
    logic [REG_INDEX_W-1:0] reg_index;
    logic                   wr_en;

    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && (reg_index == REG_LARGEST_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            limit_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        if (reg_index == REG_LARGEST_COUNT)
        begin
            prdata = APB_DATA_W'(limit_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    assign limit = limit_reg;

endmodule

`default_nettype wire

@@ src/bra_div.sv @@
// ----------------------------------------------------------------------------
// bra_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_div #(
    parameter int W = 31
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic      [W-1:0] quotient,
    output logic      [W-1:0] remainder,
    output logic              done
);
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quot_reg;
    logic [W-1:0]     den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [W:0]       partial;
    logic [W:0]       trial;
    logic             fits;

    // shift in the next dividend bit, then try a subtract
    assign partial = {rem_reg, quot_reg[W-1]};
    assign trial   = partial - {1'b0, den_reg};
    assign fits    = !trial[W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            den_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? trial[W-1:0] : partial[W-1:0];
            quot_reg <= {quot_reg[W-2:0], fits};
        end
    end

    assign quotient  = quot_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

@@ src/bra_mac.sv @@
// ----------------------------------------------------------------------------
// bra_mac
// Multiply-accumulate unit: narrow operand times a wide operand taken one
// chunk a cycle, most significant chunk first, plus an addend.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_mac #(
    parameter int XW     = 17,
    parameter int CHUNKS = 3,
    parameter int ACC_W  = 68,
    parameter int CNT_W  = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [XW-1:0]        x,
    input  wire logic [CHUNKS*XW-1:0] y,
    input  wire logic [ACC_W-1:0]     addend,
    input  wire logic [CNT_W-1:0]     count,
    output logic      [ACC_W-1:0]     acc,
    output logic                      done
);
    localparam int YW = CHUNKS * XW;

    logic [XW-1:0]    x_reg;
    logic [YW-1:0]    y_reg;
    logic [ACC_W-1:0] addend_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             first_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [2*XW-1:0]  prod;
    logic [ACC_W-1:0] base;
    logic [ACC_W-1:0] acc_next;

    assign prod     = x_reg * y_reg[YW-1 -: XW];
    assign base     = first_reg ? addend_reg : (acc_reg << XW);
    assign acc_next = base + ACC_W'(prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= count;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg      <= x;
            y_reg      <= y;
            addend_reg <= addend;
            first_reg  <= 1'b1;
        end
        else if (busy_reg)
        begin
            acc_reg   <= acc_next;
            y_reg     <= y_reg << XW;
            first_reg <= 1'b0;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ src/best_rational_approximation.sv @@
// ----------------------------------------------------------------------------
// best_rational_approximation
// Best bounded fraction first_count / second_count for a fixed-point ratio.
// ----------------------------------------------------------------------------
// One request at a time. A nonpositive ratio goes from idle straight to the
// final state and into the output register. Otherwise each continued-fraction
// term costs one divide on the bit-serial DW-bit divider (DW = max(RATIO_WIDTH-1,
// FRACTION_BITS+1, 17)) plus a check state and two single-chunk multiply-adds.
// When the limit is reached after a first convergent, one more divide and eight
// multiply-adds on the shared unit (six of them over NEC = ceil((17+DW)/17)
// chunks) choose between the convergent and the semiconvergent. in_ready is
// high only while the block is idle; a finished result waits in the output
// register and the next request may be taken meanwhile.
`default_nettype none

module best_rational_approximation #(
    parameter int FRACTION_BITS = bra_pkg::FRACTION_BITS_DEF,
    parameter int RATIO_WIDTH   = bra_pkg::RATIO_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [RATIO_WIDTH-1:0]  ratio_value,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                found,
    output logic      [bra_pkg::COUNT_W-1:0]    first_count,
    output logic      [bra_pkg::COUNT_W-1:0]    second_count,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bra_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [bra_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [bra_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import bra_pkg::*;

    localparam int CW     = COUNT_W;
    localparam int DW_RAW = (RATIO_WIDTH - 1 > FRACTION_BITS + 1) ?
                            RATIO_WIDTH - 1 : FRACTION_BITS + 1;
    localparam int DW     = (DW_RAW > CW) ? DW_RAW : CW;
    localparam int PW     = CW + DW;
    localparam int NEC    = (PW + CW - 1) / CW;
    localparam int YW     = NEC * CW;
    localparam int AW     = (NEC + 1) * CW;
    localparam int MCW    = $clog2(NEC + 1);

    // configuration
    logic [CW-1:0] limit;

    bra_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limit   (limit)
    );

    // sequencer
    bra_state_t state_reg;
    bra_state_t state_next;
    logic       issue_reg;

    // datapath registers
    logic [DW-1:0] n_reg;
    logic [DW-1:0] d_reg;
    logic [DW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic          invert_reg;
    logic          fail_reg;
    logic [CW-1:0] p0_reg;
    logic [CW-1:0] q0_reg;
    logic [CW-1:0] p1_reg;
    logic [CW-1:0] q1_reg;
    logic [CW-1:0] q2_reg;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] sp_reg;
    logic [CW-1:0] sq_reg;
    logic [AW-1:0] tmp_reg;
    logic [PW-1:0] e1_reg;
    logic [PW-1:0] e2_reg;
    logic [CW-1:0] res_p_reg;
    logic [CW-1:0] res_q_reg;

    // output register
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          found_reg;
    logic [CW-1:0] first_reg;
    logic [CW-1:0] second_reg;

    // shared units
    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [DW-1:0] div_divisor;
    logic [DW-1:0] div_quot;
    logic [DW-1:0] div_rem;
    logic          div_done;

    logic           mac_start;
    logic [CW-1:0]  mac_x;
    logic [YW-1:0]  mac_y;
    logic [AW-1:0]  mac_addend;
    logic [MCW-1:0] mac_count;
    logic [AW-1:0]  mac_acc;
    logic           mac_done;

    bra_div #(
        .W (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quot),
        .remainder (div_rem),
        .done      (div_done)
    );

    bra_mac #(
        .XW     (CW),
        .CHUNKS (NEC),
        .ACC_W  (AW),
        .CNT_W  (MCW)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_start),
        .x      (mac_x),
        .y      (mac_y),
        .addend (mac_addend),
        .count  (mac_count),
        .acc    (mac_acc),
        .done   (mac_done)
    );

    // request decode
    logic [DW-1:0] v_mag;
    logic [DW-1:0] one_dw;
    logic          nonpos;
    logic          accept;

    assign v_mag  = DW'(ratio_value[RATIO_WIDTH-2:0]);
    assign one_dw = DW'(1) << FRACTION_BITS;
    assign nonpos = ratio_value[RATIO_WIDTH-1] || (ratio_value == '0);
    assign accept = in_valid && in_ready;

    // error magnitudes from the two products held in tmp_reg and mac_acc
    logic [AW-1:0] err_abs;
    assign err_abs = (tmp_reg >= mac_acc) ? (tmp_reg - mac_acc) : (mac_acc - tmp_reg);

    // final fix-up
    logic [CW-1:0] p_fix;
    logic [CW-1:0] fin_first;
    logic [CW-1:0] fin_second;
    logic          fin_ok;
    logic          out_load;

    assign p_fix      = (res_p_reg == '0) ? CW'(1) : res_p_reg;
    assign fin_first  = invert_reg ? res_q_reg : p_fix;
    assign fin_second = invert_reg ? p_fix : res_q_reg;
    assign fin_ok     = !fail_reg && (fin_first <= limit) && (fin_second <= limit);
    assign out_load   = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = nonpos ? ST_FIN : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                // a huge term ends the expansion before any multiply
                if ((q1_reg != '0) && (div_quot > DW'(limit)))
                begin
                    state_next = ST_BRK;
                end
                else
                begin
                    state_next = ST_MQ;
                end
            end
            ST_MQ:
            begin
                if (mac_done)
                begin
                    state_next = (mac_acc > AW'(limit)) ? ST_BRK : ST_MP;
                end
            end
            ST_MP:
            begin
                if (mac_done)
                begin
                    state_next = (div_rem == '0) ? ST_FIN : ST_DIV;
                end
            end
            ST_BRK:
            begin
                state_next = (q1_reg == '0) ? ST_FIN : ST_KDIV;
            end
            ST_KDIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SP;
                end
            end
            ST_SP:   if (mac_done) state_next = ST_SQ;
            ST_SQ:   if (mac_done) state_next = ST_EA;
            ST_EA:   if (mac_done) state_next = ST_EB;
            ST_EB:   if (mac_done) state_next = ST_EC;
            ST_EC:   if (mac_done) state_next = ST_ED;
            ST_ED:   if (mac_done) state_next = ST_EE;
            ST_EE:   if (mac_done) state_next = ST_EF;
            ST_EF:   if (mac_done) state_next = ST_FIN;
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // unit controls
    always_comb
    begin
        in_ready     = 1'b0;
        div_start    = 1'b0;
        div_dividend = num_reg;
        div_divisor  = den_reg;
        mac_start    = 1'b0;
        mac_x        = '0;
        mac_y        = '0;
        mac_addend   = '0;
        mac_count    = MCW'(NEC);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_DIV:
            begin
                div_start = issue_reg;
            end
            ST_KDIV:
            begin
                div_start    = issue_reg;
                div_dividend = DW'(limit - q0_reg);
                div_divisor  = DW'(q1_reg);
            end
            ST_MQ:
            begin
                mac_start  = issue_reg;
                mac_x      = div_quot[CW-1:0];
                mac_y      = {q1_reg, {(YW - CW){1'b0}}};
                mac_addend = AW'(q0_reg);
                mac_count  = MCW'(1);
            end
            ST_MP:
            begin
                mac_start  = issue_reg;
                mac_x      = div_quot[CW-1:0];
                mac_y      = {p1_reg, {(YW - CW){1'b0}}};
                mac_addend = AW'(p0_reg);
                mac_count  = MCW'(1);
            end
            ST_SP:
            begin
                mac_start  = issue_reg;
                mac_x      = k_reg;
                mac_y      = {p1_reg, {(YW - CW){1'b0}}};
                mac_addend = AW'(p0_reg);
                mac_count  = MCW'(1);
            end
            ST_SQ:
            begin
                mac_start  = issue_reg;
                mac_x      = k_reg;
                mac_y      = {q1_reg, {(YW - CW){1'b0}}};
                mac_addend = AW'(q0_reg);
                mac_count  = MCW'(1);
            end
            ST_EA:
            begin
                mac_start = issue_reg;
                mac_x     = sp_reg;
                mac_y     = YW'(d_reg);
            end
            ST_EB:
            begin
                mac_start = issue_reg;
                mac_x     = sq_reg;
                mac_y     = YW'(n_reg);
            end
            ST_EC:
            begin
                mac_start = issue_reg;
                mac_x     = p1_reg;
                mac_y     = YW'(d_reg);
            end
            ST_ED:
            begin
                mac_start = issue_reg;
                mac_x     = q1_reg;
                mac_y     = YW'(n_reg);
            end
            ST_EE:
            begin
                mac_start = issue_reg;
                mac_x     = q1_reg;
                mac_y     = YW'(e1_reg);
            end
            ST_EF:
            begin
                mac_start = issue_reg;
                mac_x     = sq_reg;
                mac_y     = YW'(e2_reg);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= (state_next != state_reg);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    invert_reg <= (v_mag > one_dw);
                    fail_reg   <= nonpos;
                    n_reg      <= (v_mag > one_dw) ? one_dw : v_mag;
                    d_reg      <= (v_mag > one_dw) ? v_mag : one_dw;
                    num_reg    <= (v_mag > one_dw) ? one_dw : v_mag;
                    den_reg    <= (v_mag > one_dw) ? v_mag : one_dw;
                    p0_reg     <= '0;
                    q0_reg     <= CW'(1);
                    p1_reg     <= CW'(1);
                    q1_reg     <= '0;
                end
            end
            ST_MQ:
            begin
                if (mac_done)
                begin
                    q2_reg <= mac_acc[CW-1:0];
                end
            end
            ST_MP:
            begin
                if (mac_done)
                begin
                    p0_reg    <= p1_reg;
                    q0_reg    <= q1_reg;
                    p1_reg    <= mac_acc[CW-1:0];
                    q1_reg    <= q2_reg;
                    num_reg   <= den_reg;
                    den_reg   <= div_rem;
                    res_p_reg <= mac_acc[CW-1:0];
                    res_q_reg <= q2_reg;
                end
            end
            ST_BRK:
            begin
                // no convergent fits: fall back to the seed fraction
                res_p_reg <= p0_reg;
                res_q_reg <= q0_reg;
            end
            ST_KDIV:
            begin
                if (div_done)
                begin
                    k_reg <= div_quot[CW-1:0];
                end
            end
            ST_SP:
            begin
                if (mac_done)
                begin
                    sp_reg <= mac_acc[CW-1:0];
                end
            end
            ST_SQ:
            begin
                if (mac_done)
                begin
                    sq_reg <= mac_acc[CW-1:0];
                end
            end
            ST_EA, ST_EC, ST_EE:
            begin
                if (mac_done)
                begin
                    tmp_reg <= mac_acc;
                end
            end
            ST_EB:
            begin
                if (mac_done)
                begin
                    e1_reg <= err_abs[PW-1:0];
                end
            end
            ST_ED:
            begin
                if (mac_done)
                begin
                    e2_reg <= err_abs[PW-1:0];
                end
            end
            ST_EF:
            begin
                if (mac_done)
                begin
                    // semiconvergent wins a tie
                    if (tmp_reg <= mac_acc)
                    begin
                        res_p_reg <= sp_reg;
                        res_q_reg <= sq_reg;
                    end
                    else
                    begin
                        res_p_reg <= p1_reg;
                        res_q_reg <= q1_reg;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    found_reg  <= fin_ok;
                    first_reg  <= fin_ok ? fin_first : '0;
                    second_reg <= fin_ok ? fin_second : '0;
                end
            end
            default:
            begin
                tmp_reg <= tmp_reg;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign first_count  = first_reg;
    assign second_count = second_reg;

endmodule

`default_nettype wire

@@ src/bra_checker.sv @@
// ----------------------------------------------------------------------------
// bra_checker
// Port-level checks on the best rational approximation block.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic                        found,
    input wire logic [bra_pkg::COUNT_W-1:0] first_count,
    input wire logic [bra_pkg::COUNT_W-1:0] second_count
);
    import bra_pkg::*;

    // a rejected ratio carries empty counts
    a_not_found_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> ((first_count == '0) && (second_count == '0)))
        else $error("not-found result with nonzero counts");

    // a fraction that was found never has a zero term
    a_found_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> ((first_count != '0) && (second_count != '0)))
        else $error("found result with a zero count");

    // a request always keeps the block busy for at least the next cycle
    a_busy_after_request : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready straight after a request");

    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(found)
            && $stable(first_count) && $stable(second_count)))
        else $error("stalled result changed");

endmodule

bind best_rational_approximation bra_checker u_bra_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .first_count  (first_count),
    .second_count (second_count)
);

`default_nettype wire

@@ tb/bra_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_result_checker
// Watches the configuration port and both handshake channels of the best
// rational approximation block. Each accepted ratio is turned into the
// expected bounded fraction by exact Euclid steps and queued. Each accepted
// result is compared field by field with the oldest queued fraction.
// ----------------------------------------------------------------------------
module bra_result_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_ready,
    input  wire logic [bra_pkg::RATIO_WIDTH_DEF-1:0]  ratio_value,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_ready,
    input  wire logic                                 found,
    input  wire logic [bra_pkg::COUNT_W-1:0]          first_count,
    input  wire logic [bra_pkg::COUNT_W-1:0]          second_count,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic                                 pready,
    input  wire logic [bra_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [bra_pkg::APB_DATA_W-1:0]       pwdata,
    output int                                        mismatches,
    output int                                        awaited
);

    localparam int FRAC_BITS = bra_pkg::FRACTION_BITS_DEF;
    localparam int RATIO_W   = bra_pkg::RATIO_WIDTH_DEF;
    localparam int CW        = bra_pkg::COUNT_W;

    typedef struct packed {
        logic          found;
        logic [CW-1:0] numer;
        logic [CW-1:0] denom;
    } fraction_t;

    fraction_t       pending_fractions[$];
    logic [CW-1:0]   count_limit;

    // best p/q for n/d with 0 < n <= d, denominators bounded by lim
    function automatic void bounded_convergent(input bit [63:0] n, input bit [63:0] d,
                                               input bit [63:0] lim,
                                               output bit [63:0] rp, output bit [63:0] rq);
        bit [63:0]  p0, q0, p1, q1, p2, q2, num, den, a, rem;
        bit [63:0]  k, sp, sq, e1, e2, x, y;
        bit [127:0] lhs, rhs;
        bit         stop, exact;
        p0 = 0; q0 = 1; p1 = 1; q1 = 0;
        num = n; den = d;
        stop = 0; exact = 0;
        while (!stop)
        begin
            a   = num / den;
            rem = num - a * den;
            q2  = a * q1 + q0;
            if ((q1 != 0 && a > lim) || q2 > lim)
                stop = 1;
            else
            begin
                p2 = a * p1 + p0;
                p0 = p1; q0 = q1;
                p1 = p2; q1 = q2;
                if (rem == 0)
                begin
                    exact = 1;
                    stop  = 1;
                end
                else
                begin
                    num = den;
                    den = rem;
                end
            end
        end
        if (exact)
        begin
            rp = p1; rq = q1;
        end
        else if (q1 == 0)
        begin
            rp = p0; rq = q0;
        end
        else
        begin
            // semiconvergent against last convergent, exact cross-multiplied distances
            k  = (lim - q0) / q1;
            sp = p0 + k * p1;
            sq = q0 + k * q1;
            x  = sp * d; y = n * sq;
            e1 = (x >= y) ? x - y : y - x;
            x  = p1 * d; y = n * q1;
            e2 = (x >= y) ? x - y : y - x;
            lhs = 128'(e1) * 128'(q1);
            rhs = 128'(e2) * 128'(sq);
            if (lhs <= rhs)
            begin
                rp = sp; rq = sq;
            end
            else
            begin
                rp = p1; rq = q1;
            end
        end
    endfunction

    function automatic fraction_t predict_fraction(input logic [RATIO_W-1:0] ratio,
                                                   input logic [CW-1:0] lim_reg);
        fraction_t res;
        bit [63:0] v, unity, n, d, p, q, lim, t;
        bit        flip;
        res   = '0;
        v     = 64'(ratio);
        unity = 64'd1 << FRAC_BITS;
        lim   = 64'(lim_reg);
        if (v == 0 || ratio[RATIO_W-1])
            return res;
        // above one: approximate the reciprocal and swap afterwards
        flip = v > unity;
        if (flip)
        begin
            n = unity; d = v;
        end
        else
        begin
            n = v; d = unity;
        end
        bounded_convergent(n, d, lim, p, q);
        if (p == 0)
            p = 1;
        if (flip)
        begin
            t = p; p = q; q = t;
        end
        if (p > lim || q > lim)
            return res;
        res.found = 1'b1;
        res.numer = CW'(p);
        res.denom = CW'(q);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fraction_t want;
        if (!rst_n)
        begin
            count_limit = bra_pkg::LIMIT_RESET;
            pending_fractions.delete();
            mismatches = 0;
            awaited    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr[bra_pkg::APB_ADDR_W-1:2] == bra_pkg::REG_LARGEST_COUNT)
                count_limit = pwdata[CW-1:0];
            if (in_valid && in_ready)
                pending_fractions = {pending_fractions,
                                     predict_fraction(ratio_value, count_limit)};
            if (out_valid && out_ready)
            begin
                if (pending_fractions.size() == 0)
                begin
                    $error("unexpected result: no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_fractions.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, found);
                        mismatches++;
                    end
                    if (first_count !== want.numer)
                    begin
                        $error("first_count: expected %0d, got %0d", want.numer, first_count);
                        mismatches++;
                    end
                    if (second_count !== want.denom)
                    begin
                        $error("second_count: expected %0d, got %0d", want.denom,
                               second_count);
                        mismatches++;
                    end
                end
            end
            awaited = pending_fractions.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives ratio requests and limit writes into the best rational approximation
// block under random idling on both channels, with one long output hold-off,
// and leaves prediction and comparison to the checker beside it.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RATIO_W = bra_pkg::RATIO_WIDTH_DEF;
    localparam logic [bra_pkg::APB_ADDR_W-1:0] LIMIT_ADDR = {bra_pkg::REG_LARGEST_COUNT, 2'b00};

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                in_valid     = 1'b0;
    logic signed [RATIO_W-1:0]           ratio_value  = '0;
    logic                                out_ready    = 1'b0;
    logic                                psel         = 1'b0;
    logic                                penable      = 1'b0;
    logic                                pwrite       = 1'b0;
    logic [bra_pkg::APB_ADDR_W-1:0]      paddr        = '0;
    logic [bra_pkg::APB_DATA_W-1:0]      pwdata       = '0;

    wire logic                           in_ready;
    wire logic                           out_valid;
    wire logic                           found;
    wire logic [bra_pkg::COUNT_W-1:0]    first_count;
    wire logic [bra_pkg::COUNT_W-1:0]    second_count;
    wire logic [bra_pkg::APB_DATA_W-1:0] prdata;
    wire logic                           pready;

    int mismatches;
    int awaited;
    bit long_hold_req = 1'b0;
    bit calm          = 1'b0;

    best_rational_approximation uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ratio_value  (ratio_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .first_count  (first_count),
        .second_count (second_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    bra_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ratio_value  (ratio_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .first_count  (first_count),
        .second_count (second_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (mismatches),
        .awaited      (awaited)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #150_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic signed [RATIO_W-1:0] random_ratio();
        logic [RATIO_W-1:0] t;
        int                 pick;
        int                 a;
        int                 b;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            t = $urandom | 32'h8000_0000;
        else if (pick < 17)
            t = '0;
        else if (pick < 40)
            t = $urandom_range(1, 65536);
        else if (pick < 55)
            t = $urandom_range(65537, 65536 * 64);
        else if (pick < 70)
            t = $urandom & 32'h7FFF_FFFF;
        else if (pick < 78)
            t = $urandom_range(1, 255);
        else if (pick < 88)
        begin
            // coarse values whose reduced denominator is small
            t = 32'($urandom_range(1, 65535)) << $urandom_range(0, 15);
            t[RATIO_W-1] = 1'b0;
            if (t == 0)
                t = 1;
        end
        else if (pick < 94)
        begin
            // close to a simple fraction
            a = $urandom_range(1, 60);
            b = $urandom_range(1, 60);
            t = 32'((a * 65536) / b + $urandom_range(0, 2) - 1);
            t[RATIO_W-1] = 1'b0;
        end
        else
        begin
            case ($urandom_range(0, 6))
                0: t = 32'h0000_0001;
                1: t = 32'h0000_FFFF;
                2: t = 32'h0001_0000;
                3: t = 32'h0001_0001;
                4: t = 32'h7FFF_FFFF;
                5: t = 32'h8000_0000;
                default: t = 32'hFFFF_FFFF;
            endcase
        end
        return t;
    endfunction

    task automatic offer_ratio(input logic signed [RATIO_W-1:0] v);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 50)
            gap = 0;
        else if (pick < 85)
            gap = $urandom_range(1, 3);
        else if (pick < 97)
            gap = $urandom_range(5, 40);
        else
            gap = $urandom_range(100, 400);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        ratio_value <= v;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic run_requests(input int count);
        repeat (count) offer_ratio(random_ratio());
    endtask

    // limit changes only once every outstanding request has been answered
    task automatic write_limit(input logic [bra_pkg::APB_DATA_W-1:0] data);
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // result side
    initial
    begin
        int pick;
        int span;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            pick = $urandom_range(0, 99);
            if (long_hold_req)
            begin
                // long hold-off so the block fills and stalls its request side
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                span = 3000;
            end
            else if (calm)
            begin
                out_ready <= 1'b1;
                span = 1;
            end
            else if (pick < 55)
            begin
                out_ready <= 1'b1;
                span = $urandom_range(1, 40);
            end
            else if (pick < 90)
            begin
                out_ready <= 1'b0;
                span = $urandom_range(1, 3);
            end
            else if (pick < 98)
            begin
                out_ready <= 1'b0;
                span = $urandom_range(10, 60);
            end
            else
            begin
                out_ready <= 1'b0;
                span = $urandom_range(200, 600);
            end
            repeat (span) @(posedge clk);
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sign extremes and zero
        offer_ratio(32'sh0000_0000);
        offer_ratio(32'shFFFF_FFFF);
        offer_ratio(32'sh8000_0000);
        offer_ratio(32'sh7FFF_FFFF);
        offer_ratio(32'shAAAA_AAAA);
        offer_ratio(32'sh5555_5555);
        // around one, smallest steps and exact values
        offer_ratio(32'sh0000_0001);
        offer_ratio(32'sh0000_0003);
        offer_ratio(32'sh0000_FFFF);
        offer_ratio(32'sh0001_0000);
        offer_ratio(32'sh0001_0001);
        offer_ratio(32'sh0000_8000);
        offer_ratio(32'sh0003_0000);
        // irrational-looking values that need the semiconvergent test
        offer_ratio(32'sh0003_243F);
        offer_ratio(32'sh0002_B7E1);
        offer_ratio(32'sh0000_B505);
        offer_ratio(32'sh0000_5555);

        long_hold_req = 1'b1;
        run_requests(250);

        write_limit(32'd131071);
        calm = 1'b1;
        run_requests(40);
        calm = 1'b0;
        run_requests(220);

        // tiny limits force zero numerators and out-of-limit swaps
        write_limit(32'd1);
        run_requests(120);
        write_limit(32'd0);
        run_requests(30);
        write_limit(32'd2);
        run_requests(100);

        write_limit(32'($urandom_range(3, 400)));
        run_requests(250);
        write_limit(32'($urandom_range(1, 131071)));
        run_requests(280);
        write_limit(32'd65535);
        run_requests(160);
        // bits above the register are dropped
        write_limit({15'($urandom), 17'd65536});
        run_requests(180);
        in_valid <= 1'b0;

        @(posedge clk);
        while (awaited != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
src/bra_pkg.sv
src/bra_cfg.sv
src/bra_div.sv
src/bra_mac.sv
src/best_rational_approximation.sv
src/bra_checker.sv
tb/bra_checker.sv
tb/testbench.sv
